// ===== rtl/xsfg_pkg.sv =====
// ----------------------------------------------------------------------------
// xsfg_pkg
// Shared types, constants and command codes of the xorshift family generator.
// ----------------------------------------------------------------------------
package xsfg_pkg;

  localparam int unsigned NumWords = 16;
  localparam int unsigned WordW    = 64;
  localparam int unsigned IdxW     = 4;

  localparam logic [63:0] SmGolden = 64'h9e3779b97f4a7c15;
  localparam logic [63:0] SmMul1   = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] SmMul2   = 64'h94d049bb133111eb;
  localparam logic [63:0] Xs64Mul  = 64'h2545f4914f6cdd1d;
  localparam logic [63:0] Xs1024Mul = 64'd1181783497276652981;

  typedef enum logic [1:0] {
    CMD_GEN  = 2'd0,
    CMD_SEED = 2'd1,
    CMD_SEL  = 2'd2,
    CMD_NONE = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ALG_XS64    = 3'd0,
    ALG_XS64S   = 3'd1,
    ALG_XS128P  = 3'd2,
    ALG_X256PP  = 3'd3,
    ALG_X256SS  = 3'd4,
    ALG_X256P   = 3'd5,
    ALG_XS1024S = 3'd6,
    ALG_BAD     = 3'd7
  } alg_e;

  // Datapath operations issued by the controller.
  typedef enum logic [2:0] {
    OP_NOP,     // hold
    OP_LOAD,    // capture item payload
    OP_DRAW1,   // state update, product operand registered
    OP_MUL,     // one step of the 32x32 multiply sequence
    OP_SM,      // one splitmix round step
    OP_WRITE,   // write splitmix result into word index
    OP_CLEAR,   // zero all words and ring position, switch algorithm
    OP_RESULT   // latch result word
  } op_e;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE, ST_DECODE, ST_DRAW, ST_MUL, ST_SM, ST_WRITE, ST_RESULT, ST_OUT
  } ctrl_st_e;

  typedef struct packed {
    op_e             op;
    logic [2:0]      sm_step;   // splitmix sub-step
    logic [1:0]      mul_step;  // three partial products, then take
    logic            sm_zero;   // splitmix input is zero instead of seed
    logic [IdxW-1:0] widx;      // word write index
    logic            res_zero;  // result is zero
  } dp_cmd_t;

  typedef struct packed {
    cmd_e       cmd;
    alg_e       alg;
    alg_e       cur_alg;
  } dp_sts_t;

  function automatic logic [4:0] words_used(alg_e a);
    unique case (a)
      ALG_XS64, ALG_XS64S:             words_used = 5'd1;
      ALG_XS128P:                       words_used = 5'd2;
      ALG_X256PP, ALG_X256SS, ALG_X256P: words_used = 5'd4;
      default:                          words_used = 5'd16;
    endcase
  endfunction

endpackage

// ===== rtl/xsfg_if.sv =====
// ----------------------------------------------------------------------------
// xsfg_in_if / xsfg_out_if
// Valid/ready channels for command items and result items.
// ----------------------------------------------------------------------------
interface xsfg_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [63:0] seed_value;
  logic [2:0]  algo;
  modport source (output valid, cmd, seed_value, algo, input ready);
  modport sink   (input valid, cmd, seed_value, algo, output ready);
endinterface

interface xsfg_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] random_word;
  modport source (output valid, random_word, input ready);
  modport sink   (input valid, random_word, output ready);
endinterface

// ===== rtl/xsfg_datapath.sv =====
// ----------------------------------------------------------------------------
// xsfg_datapath
// Generator words, algorithm step, output multiply and splitmix unit.
// ----------------------------------------------------------------------------
module xsfg_datapath (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_en_i,
  input  logic [1:0]       cmd_i,
  input  logic [63:0]      seed_i,
  input  logic [2:0]       algo_i,
  input  xsfg_pkg::dp_cmd_t dp_cmd_i,
  output xsfg_pkg::dp_sts_t dp_sts_o,
  output logic [63:0]      result_o
);

  logic [63:0] words_q [xsfg_pkg::NumWords];
  logic [63:0] words_d [xsfg_pkg::NumWords];
  logic [xsfg_pkg::IdxW-1:0] ring_q, ring_d;
  xsfg_pkg::alg_e alg_q, alg_d;
  logic [1:0]  icmd_q;
  logic [2:0]  ialg_q;
  logic [63:0] seed_q;
  logic [63:0] opa_q, opa_d, opb_q, opb_d;   // multiply operands
  logic [63:0] acc_q, acc_d;                 // draw value / splitmix work
  logic [63:0] res_q, res_d;
  logic [63:0] mp_q, mp_d;                   // product accumulator
  logic        mul_pending_q, mul_pending_d;

  // One 32x32 multiplier; low 64 bits of the full product in three steps:
  // lo*lo, then lo*hi and hi*lo added into the upper half.
  logic [31:0] mul_a, mul_b;
  logic [63:0] mprod;

  always_comb begin
    unique case (dp_cmd_i.mul_step)
      2'd0: begin mul_a = opa_q[31:0]; mul_b = opb_q[31:0]; end
      2'd1: begin mul_a = opa_q[31:0]; mul_b = opb_q[63:32]; end
      default: begin mul_a = opa_q[63:32]; mul_b = opb_q[31:0]; end
    endcase
  end

  assign mprod = {32'd0, mul_a} * {32'd0, mul_b};

  function automatic logic [63:0] rotl(logic [63:0] x, int unsigned k);
    rotl = (x << k) | (x >> (64 - k));
  endfunction

  always_comb begin
    logic [63:0] t, s, r, tt;
    logic [xsfg_pkg::IdxW-1:0] p;
    for (int i = 0; i < xsfg_pkg::NumWords; i++) words_d[i] = words_q[i];
    ring_d = ring_q;
    alg_d = alg_q;
    opa_d = opa_q;
    opb_d = opb_q;
    acc_d = acc_q;
    res_d = res_q;
    mp_d = mp_q;
    mul_pending_d = mul_pending_q;
    t = '0; s = '0; r = '0; tt = '0; p = '0;
    unique case (dp_cmd_i.op)
      xsfg_pkg::OP_DRAW1: begin
        mul_pending_d = 1'b0;
        unique case (alg_q)
          xsfg_pkg::ALG_XS64: begin
            t = words_q[0];
            t ^= t << 13; t ^= t >> 7; t ^= t << 17;
            words_d[0] = t; acc_d = t;
          end
          xsfg_pkg::ALG_XS64S: begin
            t = words_q[0];
            t ^= t >> 12; t ^= t << 25; t ^= t >> 27;
            words_d[0] = t;
            opa_d = t; opb_d = xsfg_pkg::Xs64Mul; mul_pending_d = 1'b1;
          end
          xsfg_pkg::ALG_XS128P: begin
            t = words_q[0]; s = words_q[1];
            words_d[0] = s;
            t ^= t << 23; t ^= t >> 18; t ^= s ^ (s >> 5);
            words_d[1] = t; acc_d = t + s;
          end
          xsfg_pkg::ALG_X256PP, xsfg_pkg::ALG_X256SS, xsfg_pkg::ALG_X256P: begin
            if (alg_q == xsfg_pkg::ALG_X256PP)
              acc_d = rotl(words_q[0] + words_q[3], 23) + words_q[0];
            else if (alg_q == xsfg_pkg::ALG_X256SS) begin
              r = rotl((words_q[1] << 2) + words_q[1], 7);
              acc_d = (r << 3) + r;
            end else
              acc_d = words_q[0] + words_q[3];
            tt = words_q[1] << 17;
            words_d[2] = words_q[2] ^ words_q[0];
            words_d[3] = words_q[3] ^ words_q[1];
            words_d[1] = words_q[1] ^ words_d[2];
            words_d[0] = words_q[0] ^ words_d[3];
            words_d[2] = words_d[2] ^ tt;
            words_d[3] = rotl(words_d[3], 45);
          end
          default: begin
            s = words_q[ring_q];
            p = ring_q + 1'b1;
            t = words_q[p];
            t ^= t << 31; t ^= t >> 11; t ^= s ^ (s >> 30);
            words_d[p] = t; ring_d = p;
            opa_d = t; opb_d = xsfg_pkg::Xs1024Mul; mul_pending_d = 1'b1;
          end
        endcase
      end
      xsfg_pkg::OP_MUL: begin
        unique case (dp_cmd_i.mul_step)
          2'd0: mp_d = mprod;
          2'd1, 2'd2: mp_d = mp_q + {mprod[31:0], 32'd0};
          default: begin
            if (mul_pending_q) acc_d = mp_q;
            mul_pending_d = 1'b0;
          end
        endcase
      end
      xsfg_pkg::OP_SM: begin
        // steps: 0 add, 1 mix1 operands, 2 mix2 operands, 3 final xor;
        // the multiply sequence runs after steps 1 and 2
        unique case (dp_cmd_i.sm_step)
          3'd0: acc_d = (dp_cmd_i.sm_zero ? 64'd0 : seed_q) + xsfg_pkg::SmGolden;
          3'd1: begin
            opa_d = acc_q ^ (acc_q >> 30); opb_d = xsfg_pkg::SmMul1;
            mul_pending_d = 1'b1;
          end
          3'd2: begin
            opa_d = acc_q ^ (acc_q >> 27); opb_d = xsfg_pkg::SmMul2;
            mul_pending_d = 1'b1;
          end
          default: acc_d = acc_q ^ (acc_q >> 31);
        endcase
      end
      xsfg_pkg::OP_WRITE: words_d[dp_cmd_i.widx] = acc_q;
      xsfg_pkg::OP_CLEAR: begin
        for (int i = 0; i < xsfg_pkg::NumWords; i++) words_d[i] = '0;
        ring_d = '0;
        alg_d = xsfg_pkg::alg_e'(ialg_q);
      end
      xsfg_pkg::OP_RESULT: res_d = dp_cmd_i.res_zero ? 64'd0 : acc_q;
      default: ;
    endcase
  end

  // Seed register: item seed on load, drawn value on a switch.
  logic [63:0] seed_d;
  always_comb begin
    seed_d = seed_q;
    if (load_en_i) seed_d = seed_i;
    else if (dp_cmd_i.op == xsfg_pkg::OP_CLEAR) seed_d = acc_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < xsfg_pkg::NumWords; i++) words_q[i] <= '0;
      ring_q <= '0;
      alg_q <= xsfg_pkg::ALG_XS64;
      mul_pending_q <= 1'b0;
      icmd_q <= '0;
      ialg_q <= '0;
    end else begin
      for (int i = 0; i < xsfg_pkg::NumWords; i++) words_q[i] <= words_d[i];
      ring_q <= ring_d;
      alg_q <= alg_d;
      mul_pending_q <= mul_pending_d;
      if (load_en_i) begin
        icmd_q <= cmd_i;
        ialg_q <= algo_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    seed_q <= seed_d;
    opa_q <= opa_d;
    opb_q <= opb_d;
    acc_q <= acc_d;
    res_q <= res_d;
    mp_q <= mp_d;
  end

  assign dp_sts_o.cmd = xsfg_pkg::cmd_e'(icmd_q);
  assign dp_sts_o.alg = xsfg_pkg::alg_e'(ialg_q);
  assign dp_sts_o.cur_alg = alg_q;
  assign result_o = res_q;

endmodule

// ===== rtl/xsfg_ctrl.sv =====
// ----------------------------------------------------------------------------
// xsfg_ctrl
// Sequencer for generate, seed and algorithm switch.
// ----------------------------------------------------------------------------
module xsfg_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              load_en_o,
  output xsfg_pkg::dp_cmd_t dp_cmd_o,
  input  xsfg_pkg::dp_sts_t dp_sts_i
);

  xsfg_pkg::ctrl_st_e st_q, st_d;
  logic [2:0] sm_q, sm_d;
  logic [1:0] mcnt_q, mcnt_d;   // multiply step
  logic       mret_q, mret_d;   // multiply belongs to a splitmix round
  logic [4:0] idx_q, idx_d;     // next word index to write
  logic       sw_q, sw_d;       // draw belongs to an algorithm switch
  logic       zero_q, zero_d;   // result is zero

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= xsfg_pkg::ST_IDLE; sm_q <= '0; idx_q <= '0; sw_q <= 1'b0; zero_q <= 1'b0;
      mcnt_q <= '0; mret_q <= 1'b0;
    end else begin
      st_q <= st_d; sm_q <= sm_d; idx_q <= idx_d; sw_q <= sw_d; zero_q <= zero_d;
      mcnt_q <= mcnt_d; mret_q <= mret_d;
    end
  end

  always_comb begin
    st_d = st_q; sm_d = sm_q; idx_d = idx_q; sw_d = sw_q; zero_d = zero_q;
    mcnt_d = mcnt_q; mret_d = mret_q;
    in_ready_o = 1'b0;
    load_en_o = 1'b0;
    dp_cmd_o = '{op: xsfg_pkg::OP_NOP, sm_step: sm_q, mul_step: mcnt_q,
                 sm_zero: (idx_q != 5'd0), widx: idx_q[3:0], res_zero: zero_q};
    unique case (st_q)
      xsfg_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          load_en_o = 1'b1;
          st_d = xsfg_pkg::ST_DECODE;
        end
      end
      xsfg_pkg::ST_DECODE: begin
        sw_d = 1'b0; zero_d = 1'b1; sm_d = '0; idx_d = '0;
        mcnt_d = '0; mret_d = 1'b0;
        priority if (dp_sts_i.cmd == xsfg_pkg::CMD_GEN) begin
          zero_d = 1'b0; st_d = xsfg_pkg::ST_DRAW;
        end else if (dp_sts_i.cmd == xsfg_pkg::CMD_SEED) begin
          st_d = xsfg_pkg::ST_SM;
        end else if (dp_sts_i.cmd == xsfg_pkg::CMD_SEL &&
                     dp_sts_i.alg != xsfg_pkg::ALG_BAD &&
                     dp_sts_i.alg != dp_sts_i.cur_alg) begin
          sw_d = 1'b1; st_d = xsfg_pkg::ST_DRAW;
        end else begin
          st_d = xsfg_pkg::ST_RESULT;
        end
      end
      xsfg_pkg::ST_DRAW: begin
        dp_cmd_o.op = xsfg_pkg::OP_DRAW1;
        st_d = xsfg_pkg::ST_MUL;
      end
      xsfg_pkg::ST_MUL: begin
        // four steps: three partial products, then take the product
        dp_cmd_o.op = xsfg_pkg::OP_MUL;
        mcnt_d = mcnt_q + 2'd1;
        if (mcnt_q == 2'd3) begin
          mret_d = 1'b0;
          if (mret_q) st_d = xsfg_pkg::ST_SM;
          else st_d = sw_q ? xsfg_pkg::ST_WRITE : xsfg_pkg::ST_RESULT;
        end
      end
      xsfg_pkg::ST_WRITE: begin
        // switch: drawn value goes to seed register, words cleared
        dp_cmd_o.op = xsfg_pkg::OP_CLEAR;
        st_d = xsfg_pkg::ST_SM;
      end
      xsfg_pkg::ST_SM: begin
        dp_cmd_o.op = xsfg_pkg::OP_SM;
        if (sm_q == 3'd3) begin
          sm_d = '0; st_d = xsfg_pkg::ST_OUT;
        end else begin
          sm_d = sm_q + 3'd1;
          // steps 1 and 2 load multiply operands
          if (sm_q != 3'd0) begin
            mret_d = 1'b1; st_d = xsfg_pkg::ST_MUL;
          end
        end
      end
      xsfg_pkg::ST_OUT: begin
        // write word idx; words 1.. share splitmix(0), computed once
        dp_cmd_o.op = xsfg_pkg::OP_WRITE;
        idx_d = idx_q + 5'd1;
        if (idx_d >= xsfg_pkg::words_used(dp_sts_i.cur_alg)) st_d = xsfg_pkg::ST_RESULT;
        else if (idx_q == 5'd0) st_d = xsfg_pkg::ST_SM;
      end
      xsfg_pkg::ST_RESULT: begin
        dp_cmd_o.op = xsfg_pkg::OP_RESULT;
        st_d = xsfg_pkg::ST_IDLE;
      end
      default: st_d = xsfg_pkg::ST_IDLE;
    endcase
  end

endmodule

// ===== rtl/xorshift_family_generator_core.sv =====
// ----------------------------------------------------------------------------
// xorshift_family_generator_core
// Seven-algorithm 64-bit generator: controller plus datapath.
// Generate runs the 4-step multiply for every algorithm; seeding runs splitmix
// for word 0 and once more for all further words; a switch first draws a value
// and seeds the new algorithm from it; ignored commands return a zero result.
// Items are handled one at a time; the next item can be accepted once the
// controller is idle again; two finished items can wait before input stalls.
// Reset: words, ring position zero, algorithm xorshift64.
// ----------------------------------------------------------------------------
module xorshift_family_generator_core (
  input  logic      clk_i,
  input  logic      rst_ni,
  xsfg_in_if.sink   in_if,
  xsfg_out_if.source out_if
);

  xsfg_pkg::dp_cmd_t dp_cmd;
  xsfg_pkg::dp_sts_t dp_sts;
  logic        load_en;
  logic        ctl_ready;
  logic [63:0] dp_res;

  // Output register; a finished item waits here.
  logic        ov_q;
  logic [63:0] ow_q;
  logic        res_fire;

  // RESULT op latches into dp result; it appears there in the next cycle.
  logic res_pend_q;
  assign res_fire = (dp_cmd.op == xsfg_pkg::OP_RESULT);

  // Controller may not start a new item if a result is still pending
  // and the output slot is full.
  logic in_ok;
  assign in_ok = !(ov_q && res_pend_q);
  assign in_if.ready = ctl_ready && in_ok;

  xsfg_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i  (in_if.valid && in_ok),
    .in_ready_o  (ctl_ready),
    .load_en_o   (load_en),
    .dp_cmd_o    (dp_cmd),
    .dp_sts_i    (dp_sts)
  );

  xsfg_datapath u_dp (
    .clk_i, .rst_ni,
    .load_en_i (load_en),
    .cmd_i     (in_if.cmd),
    .seed_i    (in_if.seed_value),
    .algo_i    (in_if.algo),
    .dp_cmd_i  (dp_cmd),
    .dp_sts_o  (dp_sts),
    .result_o  (dp_res)
  );

  // Pending result moves into the output slot when the slot is free or being read out.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
      res_pend_q <= 1'b0;
    end else begin
      if (out_if.ready) ov_q <= 1'b0;
      if (res_pend_q && (!ov_q || out_if.ready)) begin
        ov_q <= 1'b1;
        res_pend_q <= 1'b0;
      end
      if (res_fire) res_pend_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_pend_q && (!ov_q || out_if.ready)) ow_q <= dp_res;
  end

  assign out_if.valid = ov_q;
  assign out_if.random_word = ow_q;

endmodule

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Testbench of the xorshift family generator: a directed table of commands,
// then random command streams, each result checked against a local model of
// all seven algorithms, with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;

  localparam int unsigned CycleLimit = 2000000;

  typedef struct {
    xsfg_pkg::cmd_e cmd;
    logic [63:0] seed;
    logic [2:0]  alg;
    logic        has_word;  // expected word typed in below
    logic [63:0] word;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  xsfg_in_if  in_if ();
  xsfg_out_if out_if ();

  xorshift_family_generator_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (in_if.sink),
    .out_if (out_if.source)
  );

  always #1 clk_i = ~clk_i;

  // Local copy of the generator state.
  logic [63:0] gen_words [16];
  logic [3:0]  ring_pos;
  logic [2:0]  cur_alg;

  logic [63:0] word_queue [$];
  int          n_fail = 0;
  int          n_words = 0;
  int          n_items = 0;
  int unsigned cycles = 0;
  logic        hold_off = 1'b0;
  logic        stim_done = 1'b0;

  function automatic logic [63:0] splitmix(logic [63:0] x);
    x = x + xsfg_pkg::SmGolden;
    x = (x ^ (x >> 30)) * xsfg_pkg::SmMul1;
    x = (x ^ (x >> 27)) * xsfg_pkg::SmMul2;
    return x ^ (x >> 31);
  endfunction

  function automatic logic [63:0] rotl(logic [63:0] x, int k);
    return (x << k) | (x >> (64 - k));
  endfunction

  task automatic advance256();
    logic [63:0] t;
    t = gen_words[1] << 17;
    gen_words[2] ^= gen_words[0];
    gen_words[3] ^= gen_words[1];
    gen_words[1] ^= gen_words[2];
    gen_words[0] ^= gen_words[3];
    gen_words[2] ^= t;
    gen_words[3] = rotl(gen_words[3], 45);
  endtask

  task automatic draw_word(output logic [63:0] r);
    logic [63:0] t, s;
    logic [3:0]  p;
    case (cur_alg)
      xsfg_pkg::ALG_XS64: begin
        t = gen_words[0];
        t ^= t << 13; t ^= t >> 7; t ^= t << 17;
        gen_words[0] = t;
        r = t;
      end
      xsfg_pkg::ALG_XS64S: begin
        t = gen_words[0];
        t ^= t >> 12; t ^= t << 25; t ^= t >> 27;
        gen_words[0] = t;
        r = t * xsfg_pkg::Xs64Mul;
      end
      xsfg_pkg::ALG_XS128P: begin
        t = gen_words[0];
        s = gen_words[1];
        gen_words[0] = s;
        t ^= t << 23; t ^= t >> 18; t ^= s ^ (s >> 5);
        gen_words[1] = t;
        r = t + s;
      end
      xsfg_pkg::ALG_X256PP: begin
        r = rotl(gen_words[0] + gen_words[3], 23) + gen_words[0];
        advance256();
      end
      xsfg_pkg::ALG_X256SS: begin
        r = rotl(gen_words[1] * 64'd5, 7) * 64'd9;
        advance256();
      end
      xsfg_pkg::ALG_X256P: begin
        r = gen_words[0] + gen_words[3];
        advance256();
      end
      default: begin
        s = gen_words[ring_pos];
        p = ring_pos + 4'd1;
        t = gen_words[p];
        t ^= t << 31; t ^= t >> 11; t ^= s ^ (s >> 30);
        gen_words[p] = t;
        ring_pos = p;
        r = t * xsfg_pkg::Xs1024Mul;
      end
    endcase
  endtask

  task automatic seed_words(logic [63:0] seed);
    int n;
    n = xsfg_pkg::words_used(xsfg_pkg::alg_e'(cur_alg));
    gen_words[0] = splitmix(seed);
    for (int i = 1; i < n; i++) gen_words[i] = splitmix(64'd0);
  endtask

  // Advance the model by one command and return its result word.
  task automatic predict_word(xsfg_pkg::cmd_e c, logic [63:0] seed, logic [2:0] a,
                              output logic [63:0] r);
    logic [63:0] v;
    r = '0;
    case (c)
      xsfg_pkg::CMD_GEN:  draw_word(r);
      xsfg_pkg::CMD_SEED: seed_words(seed);
      xsfg_pkg::CMD_SEL: begin
        if (a != xsfg_pkg::ALG_BAD && a != cur_alg) begin
          draw_word(v);
          cur_alg = a;
          foreach (gen_words[i]) gen_words[i] = '0;
          ring_pos = '0;
          seed_words(v);
        end
      end
      default: ;
    endcase
  endtask

  function automatic int gap_len();
    if ($urandom_range(0, 99) < 3) return $urandom_range(20, 60);
    if ($urandom_range(0, 99) < 40) return $urandom_range(1, 3);
    return 0;
  endfunction

  // Push one item through the handshake and record its expected word.
  task automatic send_item(xsfg_pkg::cmd_e c, logic [63:0] seed, logic [2:0] a,
                           logic has_word, logic [63:0] word);
    logic [63:0] r;
    int g;
    g = gap_len();
    if (g > 0) begin
      in_if.valid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    in_if.valid      <= 1'b1;
    in_if.cmd        <= c;
    in_if.seed_value <= seed;
    in_if.algo       <= a;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    predict_word(c, seed, a, r);
    if (has_word && r !== word) begin
      $display("%0t: table row disagrees with model: table %h model %h",
               $time, word, r);
      n_fail++;
    end
    word_queue.push_back(has_word ? word : r);
    n_items++;
  endtask

  // Directed commands. Expected words only for obvious cases.
  row_t dir_rows [$];

  task automatic fill_table();
    dir_rows = '{
      '{xsfg_pkg::CMD_GEN,  64'd0, xsfg_pkg::ALG_XS64, 1'b1, 64'd0},  // zero state
      '{xsfg_pkg::CMD_NONE, '1,    xsfg_pkg::ALG_BAD, 1'b1, 64'd0},   // unused command
      '{xsfg_pkg::CMD_SEL,  64'd0, xsfg_pkg::ALG_XS64, 1'b1, 64'd0},  // same algorithm
      '{xsfg_pkg::CMD_SEL,  64'd0, xsfg_pkg::ALG_BAD, 1'b1, 64'd0},   // algorithm seven
      '{xsfg_pkg::CMD_SEED, 64'd0, xsfg_pkg::ALG_XS64, 1'b1, 64'd0},
      '{xsfg_pkg::CMD_GEN,  64'd0, xsfg_pkg::ALG_XS64, 1'b0, 64'd0},
      '{xsfg_pkg::CMD_SEED, '1,    xsfg_pkg::ALG_X256P, 1'b1, 64'd0},
      '{xsfg_pkg::CMD_GEN,  64'd0, xsfg_pkg::ALG_XS64, 1'b0, 64'd0},
      '{xsfg_pkg::CMD_SEL,  64'd0, xsfg_pkg::ALG_XS64S, 1'b1, 64'd0},
      '{xsfg_pkg::CMD_GEN,  '1,    xsfg_pkg::ALG_BAD, 1'b0, 64'd0},
      '{xsfg_pkg::CMD_SEL,  64'd0, xsfg_pkg::ALG_XS128P, 1'b1, 64'd0},
      '{xsfg_pkg::CMD_GEN,  64'd0, xsfg_pkg::ALG_XS64, 1'b0, 64'd0},
      '{xsfg_pkg::CMD_SEL,  64'd0, xsfg_pkg::ALG_X256PP, 1'b1, 64'd0},
      '{xsfg_pkg::CMD_GEN,  64'd0, xsfg_pkg::ALG_XS64, 1'b0, 64'd0},
      '{xsfg_pkg::CMD_SEL,  64'd0, xsfg_pkg::ALG_X256SS, 1'b1, 64'd0},
      '{xsfg_pkg::CMD_GEN,  64'd0, xsfg_pkg::ALG_XS64, 1'b0, 64'd0},
      '{xsfg_pkg::CMD_SEL,  64'd0, xsfg_pkg::ALG_X256P, 1'b1, 64'd0},
      '{xsfg_pkg::CMD_GEN,  64'd0, xsfg_pkg::ALG_XS64, 1'b0, 64'd0},
      '{xsfg_pkg::CMD_SEL,  64'd0, xsfg_pkg::ALG_XS1024S, 1'b1, 64'd0},
      '{xsfg_pkg::CMD_GEN,  64'd0, xsfg_pkg::ALG_XS64, 1'b0, 64'd0},
      '{xsfg_pkg::CMD_SEED, 64'h8000_0000_0000_0001, xsfg_pkg::ALG_XS64, 1'b1, 64'd0},
      '{xsfg_pkg::CMD_GEN,  64'd0, xsfg_pkg::ALG_XS64, 1'b0, 64'd0},
      '{xsfg_pkg::CMD_SEL,  64'd0, xsfg_pkg::ALG_XS64, 1'b1, 64'd0},
      '{xsfg_pkg::CMD_GEN,  64'd0, xsfg_pkg::ALG_XS64, 1'b0, 64'd0}
    };
  endtask

  // Stimulus.
  initial begin
    xsfg_pkg::cmd_e c;
    logic [63:0] s;
    logic [2:0] a;
    int k;
    foreach (gen_words[i]) gen_words[i] = '0;
    ring_pos = '0;
    cur_alg = xsfg_pkg::ALG_XS64;
    in_if.valid <= 1'b0;
    in_if.cmd <= xsfg_pkg::CMD_GEN;
    in_if.seed_value <= '0;
    in_if.algo <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    fill_table();
    foreach (dir_rows[i])
      send_item(dir_rows[i].cmd, dir_rows[i].seed, dir_rows[i].alg,
                dir_rows[i].has_word, dir_rows[i].word);
    // Random part: mostly generate bursts, seeds and switches.
    for (int i = 0; i < 1000; i++) begin
      k = $urandom_range(0, 99);
      s = {$urandom(), $urandom()};
      a = 3'($urandom_range(0, 7));
      if (k < 65)      c = xsfg_pkg::CMD_GEN;
      else if (k < 78) c = xsfg_pkg::CMD_SEED;
      else if (k < 96) c = xsfg_pkg::CMD_SEL;
      else             c = xsfg_pkg::CMD_NONE;
      if ($urandom_range(0, 15) == 0) s = ($urandom_range(0, 1)) ? '0 : '1;
      send_item(c, s, a, 1'b0, 64'd0);
    end
    in_if.valid <= 1'b0;
    stim_done <= 1'b1;
  end

  // Long receiver hold-off early in the random part, counted in cycles.
  initial begin
    wait (n_items == 60);
    @(posedge clk_i);
    hold_off <= 1'b1;
    repeat (150) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  // Result side: random ready, compare against the oldest expectation.
  initial begin
    logic [63:0] want;
    int g;
    out_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      g = gap_len();
      if (g > 0 || hold_off) begin
        out_if.ready <= 1'b0;
        repeat (g) @(posedge clk_i);
        while (hold_off) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      @(posedge clk_i);
      while (!out_if.valid) @(posedge clk_i);
      if (word_queue.size() == 0) begin
        $display("%0t: result with no expectation: actual %h",
                 $time, out_if.random_word);
        n_fail++;
      end else begin
        want = word_queue.pop_front();
        if (out_if.random_word !== want) begin
          $display("%0t: random_word mismatch: expected %h actual %h",
                   $time, want, out_if.random_word);
          n_fail++;
        end
      end
      n_words++;
    end
  end

  // Cycle limit.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAILED: results differ");
      $finish;
    end
  end

  // End of run.
  initial begin
    wait (stim_done);
    while (word_queue.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    $display("Run covered %0d command items and %0d result words over %0d cycles,",
             n_items, n_words, cycles);
    $display("all seven algorithms, seeding, switching and ignored commands.");
    if (n_fail == 0 && word_queue.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
